### src/lslf_pkg.sv
// ----------------------------------------------------------------------------
// lslf_pkg: shared types and constants of the line fit
// Holds the fixed result format, the controller states and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package lslf_pkg;

  localparam int RESULT_WIDTH = 48;  // signed Q31.16 result
  localparam int FRAC_BITS    = 16;  // fraction bits of the result
  localparam int MIN_POINTS   = 3;   // fewest points that give a fit

  typedef enum logic [1:0] {
    FIT_OK       = 2'd0,
    FIT_FEW      = 2'd1,
    FIT_SINGULAR = 2'd2
  } fit_status_t;

  // product terms, in pairs: first term added, second term subtracted
  typedef enum logic [2:0] {
    OP_N_SXX  = 3'd0,
    OP_SX_SX  = 3'd1,
    OP_N_SXY  = 3'd2,
    OP_SX_SY  = 3'd3,
    OP_SY_SXX = 3'd4,
    OP_SX_SXY = 3'd5
  } mac_op_t;

  typedef enum logic [2:0] {
    S_ACCUM,
    S_CHECK,
    S_MAC,
    S_DEN,
    S_DIVSTART,
    S_DIV,
    S_ROUND,
    S_DONE
  } lslf_state_t;

  typedef struct packed {
    logic        acc_en;
    logic        clr_sums;
    logic        clr_acc;
    logic        mac_start;
    logic        mac_step;
    mac_op_t     mac_op;
    logic        load_den;
    logic        div_start;
    logic        div_step;
    logic        store_slope;
    logic        store_icpt;
    logic        load_out;
    fit_status_t out_status;
  } lslf_cmd_t;

  typedef struct packed {
    logic count_full;
    logic count_lt3;
    logic step_last;
    logic acc_zero;
  } lslf_sts_t;

endpackage

### src/lslf_point_if.sv
// ----------------------------------------------------------------------------
// lslf_point_if: input point channel
// One beat carries one (x, y) point and the end-of-run mark.
// ----------------------------------------------------------------------------
interface lslf_point_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] x_value;
  logic signed [SAMPLE_WIDTH-1:0] y_value;
  logic                           last_point;

  modport source (output valid, x_value, y_value, last_point, input ready);
  modport sink   (input valid, x_value, y_value, last_point, output ready);
endinterface

### src/lslf_result_if.sv
// ----------------------------------------------------------------------------
// lslf_result_if: fit result channel
// One beat carries slope, intercept and status of one run.
// ----------------------------------------------------------------------------
interface lslf_result_if import lslf_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [RESULT_WIDTH-1:0] slope;
  logic signed [RESULT_WIDTH-1:0] intercept;
  fit_status_t                    fit_status;

  modport source (output valid, slope, intercept, fit_status, input ready);
  modport sink   (input valid, slope, intercept, fit_status, output ready);
endinterface

### src/least_squares_line_fit.sv
// ----------------------------------------------------------------------------
// least_squares_line_fit: one point a cycle while the controller accumulates;
// the fit itself is worked out by a bit-serial multiplier and divider.
// Fewer than three points, or a zero denominator, end the fit early.
// Synchronous reset clears the sums, the count and the controller.
// ----------------------------------------------------------------------------
module least_squares_line_fit import lslf_pkg::*; #(
  parameter int MAX_POINTS   = 1024,
  parameter int SAMPLE_WIDTH = 16
) (
  input logic           clk,
  input logic           rst,
  lslf_point_if.sink    points,
  lslf_result_if.source results
);

  // the controller owns the handshakes and the sequence of the fit,
  // the datapath owns every sum, product, quotient and the result register

  lslf_cmd_t cmd;
  lslf_sts_t sts;
  logic      out_valid;

  // points are taken one a beat while the controller sits in accumulation;
  // a held result does not stop accumulation of the next run, only the
  // hand-off of the next fit waits for the result register to drain
  lslf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (points.valid),
    .in_last   (points.last_point),
    .in_ready  (points.ready),
    .out_valid (out_valid),
    .out_ready (results.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // fit sequence in the datapath:
  //   den = n*Sxx - Sx*Sx            (two serial products into one accumulator)
  //   slope = (n*Sxy - Sx*Sy) * 2^16 / den
  //   intercept = (Sy*Sxx - Sx*Sxy) * 2^16 / den
  // each quotient is rounded to nearest with ties away from zero and
  // clamped to the signed 48-bit range
  lslf_dp #(
    .MAX_POINTS   (MAX_POINTS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .x_value    (points.x_value),
    .y_value    (points.y_value),
    .cmd        (cmd),
    .sts        (sts),
    .slope      (results.slope),
    .intercept  (results.intercept),
    .fit_status (results.fit_status)
  );

  // one result beat per marked point
  assign results.valid = out_valid;

endmodule

### src/lslf_ctrl.sv
// ----------------------------------------------------------------------------
// lslf_ctrl: line fit sequencer
// Steps the datapath through accumulation, the six serial products, the
// two serial divisions and the hand-off to the output register.
// ----------------------------------------------------------------------------
module lslf_ctrl import lslf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  lslf_sts_t sts,
  output lslf_cmd_t cmd
);

  lslf_state_t state, state_next;
  mac_op_t     op, op_next;
  fit_status_t status_q, status_next;
  logic        out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_ACCUM;
      op        <= OP_N_SXX;
      status_q  <= FIT_OK;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      op       <= op_next;
      status_q <= status_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_next  = state;
    op_next     = op;
    status_next = status_q;
    case (state)
      S_ACCUM: begin
        if (in_valid && in_last) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.count_lt3) begin
          status_next = FIT_FEW;
          state_next  = S_DONE;
        end else begin
          op_next    = OP_N_SXX;
          state_next = S_MAC;
        end
      end
      S_MAC: begin
        if (sts.step_last) begin
          case (op)
            OP_N_SXX:  op_next = OP_SX_SX;
            OP_SX_SX:  state_next = S_DEN;
            OP_N_SXY:  op_next = OP_SX_SY;
            OP_SX_SY:  state_next = S_DIVSTART;
            OP_SY_SXX: op_next = OP_SX_SXY;
            OP_SX_SXY: state_next = S_DIVSTART;
            default:   state_next = S_ACCUM;
          endcase
        end
      end
      S_DEN: begin
        if (sts.acc_zero) begin
          status_next = FIT_SINGULAR;
          state_next  = S_DONE;
        end else begin
          op_next    = OP_N_SXY;
          state_next = S_MAC;
        end
      end
      S_DIVSTART: state_next = S_DIV;
      S_DIV: begin
        if (sts.step_last) state_next = S_ROUND;
      end
      S_ROUND: begin
        if (op == OP_SX_SY) begin
          op_next    = OP_SY_SXX;
          state_next = S_MAC;
        end else begin
          status_next = FIT_OK;
          state_next  = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) state_next = S_ACCUM;
      end
      default: state_next = S_ACCUM;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_ACCUM: begin
        in_ready   = 1'b1;
        cmd.acc_en = in_valid && !sts.count_full;
      end
      S_CHECK: begin
        if (!sts.count_lt3) begin
          cmd.clr_acc   = 1'b1;
          cmd.mac_start = 1'b1;
          cmd.mac_op    = OP_N_SXX;
        end
      end
      S_MAC: begin
        cmd.mac_step = 1'b1;
        if (sts.step_last) begin
          case (op)
            OP_N_SXX: begin
              cmd.mac_start = 1'b1;
              cmd.mac_op    = OP_SX_SX;
            end
            OP_N_SXY: begin
              cmd.mac_start = 1'b1;
              cmd.mac_op    = OP_SX_SY;
            end
            OP_SY_SXX: begin
              cmd.mac_start = 1'b1;
              cmd.mac_op    = OP_SX_SXY;
            end
            default: cmd.mac_start = 1'b0;
          endcase
        end
      end
      S_DEN: begin
        cmd.load_den = 1'b1;
        if (!sts.acc_zero) begin
          cmd.clr_acc   = 1'b1;
          cmd.mac_start = 1'b1;
          cmd.mac_op    = OP_N_SXY;
        end
      end
      S_DIVSTART: cmd.div_start = 1'b1;
      S_DIV:      cmd.div_step  = 1'b1;
      S_ROUND: begin
        if (op == OP_SX_SY) begin
          cmd.store_slope = 1'b1;
          cmd.clr_acc     = 1'b1;
          cmd.mac_start   = 1'b1;
          cmd.mac_op      = OP_SY_SXX;
        end else begin
          cmd.store_icpt = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out   = 1'b1;
          cmd.clr_sums   = 1'b1;
          cmd.out_status = status_q;
        end
      end
      default: cmd = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_load_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten while held");

  a_last_starts_fit: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> (state == S_CHECK))
    else $error("last point did not start the fit");

  a_div_ends_in_store: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && sts.step_last) |=> (cmd.store_slope || cmd.store_icpt))
    else $error("division finished without storing a quotient");
`endif

endmodule

### src/lslf_dp.sv
// ----------------------------------------------------------------------------
// lslf_dp: line fit datapath
// Running sums, a shift-add multiplier with add/subtract accumulator, a
// restoring divider with round and saturate, and the result register.
// ----------------------------------------------------------------------------
module lslf_dp import lslf_pkg::*; #(
  parameter int MAX_POINTS   = 1024,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic signed [SAMPLE_WIDTH-1:0] x_value,
  input  logic signed [SAMPLE_WIDTH-1:0] y_value,
  input  lslf_cmd_t                      cmd,
  output lslf_sts_t                      sts,
  output logic signed [RESULT_WIDTH-1:0] slope,
  output logic signed [RESULT_WIDTH-1:0] intercept,
  output fit_status_t                    fit_status
);

  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int LW  = $clog2(MAX_POINTS);
  localparam int SX  = SAMPLE_WIDTH + LW;
  localparam int SXX = 2 * SAMPLE_WIDTH + LW;
  localparam int AW  = SX + SXX + 1;
  localparam int NW  = AW + FRAC_BITS;
  localparam int SCW = $clog2(NW);
  localparam int QW  = RESULT_WIDTH + 1;

  localparam logic [CW-1:0] MaxCount = CW'(MAX_POINTS);
  localparam logic [QW:0]   LimNeg   =
    {{(QW + 1 - RESULT_WIDTH){1'b0}}, 1'b1, {(RESULT_WIDTH - 1){1'b0}}};
  localparam logic [QW:0]   LimPos   = LimNeg - (QW + 1)'(1);

  // running sums
  logic        [CW-1:0]             count;
  logic signed [SX-1:0]             sum_x, sum_y;
  logic signed [SXX-1:0]            sum_xx, sum_xy;
  logic signed [2*SAMPLE_WIDTH-1:0] prod_xx, prod_xy;

  assign prod_xx = x_value * x_value;
  assign prod_xy = x_value * y_value;

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_sums) begin
      count  <= '0;
      sum_x  <= '0;
      sum_y  <= '0;
      sum_xx <= '0;
      sum_xy <= '0;
    end else if (cmd.acc_en) begin
      count  <= count + CW'(1);
      sum_x  <= sum_x + SX'(x_value);
      sum_y  <= sum_y + SX'(y_value);
      sum_xx <= sum_xx + SXX'(prod_xx);
      sum_xy <= sum_xy + SXX'(prod_xy);
    end
  end

  // multiplier operand select
  logic signed [SX:0]   a_sel;
  logic        [SX:0]   a_abs;
  logic signed [AW-1:0] b_sel;
  logic                 op_sub;
  logic signed [SX:0]   n_ext;

  assign n_ext = $signed({{(SX + 1 - CW){1'b0}}, count});

  always_comb begin
    case (cmd.mac_op)
      OP_N_SXX: begin
        a_sel = n_ext;  b_sel = AW'(sum_xx);  op_sub = 1'b0;
      end
      OP_SX_SX: begin
        a_sel = (SX + 1)'(sum_x);  b_sel = AW'(sum_x);  op_sub = 1'b1;
      end
      OP_N_SXY: begin
        a_sel = n_ext;  b_sel = AW'(sum_xy);  op_sub = 1'b0;
      end
      OP_SX_SY: begin
        a_sel = (SX + 1)'(sum_x);  b_sel = AW'(sum_y);  op_sub = 1'b1;
      end
      OP_SY_SXX: begin
        a_sel = (SX + 1)'(sum_y);  b_sel = AW'(sum_xx);  op_sub = 1'b0;
      end
      OP_SX_SXY: begin
        a_sel = (SX + 1)'(sum_x);  b_sel = AW'(sum_xy);  op_sub = 1'b1;
      end
      default: begin
        a_sel = '0;  b_sel = '0;  op_sub = 1'b0;
      end
    endcase
  end

  assign a_abs = a_sel[SX] ? -a_sel : a_sel;

  // shared step counter for multiply and divide
  logic [SCW-1:0] step_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (cmd.mac_start) begin
      step_cnt <= SCW'(SX - 1);
    end else if (cmd.div_start) begin
      step_cnt <= SCW'(NW - 1);
    end else if ((cmd.mac_step || cmd.div_step) && step_cnt != '0) begin
      step_cnt <= step_cnt - SCW'(1);
    end
  end

  // shift-add multiplier, one multiplier bit a cycle
  logic        [SX-1:0] mplier;
  logic signed [AW-1:0] mcand;
  logic signed [AW-1:0] acc;
  logic                 mac_sub;

  always_ff @(posedge clk) begin
    if (cmd.mac_start) begin
      mplier  <= a_abs[SX-1:0];
      mcand   <= b_sel;
      mac_sub <= op_sub ^ a_sel[SX];
    end else if (cmd.mac_step) begin
      mplier <= mplier >> 1;
      mcand  <= mcand <<< 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_acc) begin
      acc <= '0;
    end else if (cmd.mac_step && mplier[0]) begin
      acc <= mac_sub ? (acc - mcand) : (acc + mcand);
    end
  end

  // restoring divider, one quotient bit a cycle
  logic [AW-1:0] den, dvd, rem;
  logic [AW:0]   rem_sh, rem_diff;
  logic          rem_ge;
  logic [QW-1:0] quo;
  logic          ovf, neg;

  assign rem_sh   = {rem, dvd[AW-1]};
  assign rem_ge   = rem_sh >= {1'b0, den};
  assign rem_diff = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (cmd.load_den) begin
      den <= acc;
    end
    if (cmd.div_start) begin
      neg <= acc[AW-1];
      dvd <= acc[AW-1] ? (-acc) : acc;
      rem <= '0;
      quo <= '0;
      ovf <= 1'b0;
    end else if (cmd.div_step) begin
      dvd <= dvd << 1;
      rem <= rem_ge ? rem_diff[AW-1:0] : rem_sh[AW-1:0];
      quo <= {quo[QW-2:0], rem_ge};
      ovf <= ovf | quo[QW-1];
    end
  end

  // round to nearest, ties away from zero, then clamp
  logic          rnd_up, q_sat;
  logic [QW:0]   q_rnd, q_lim, q_mag, q_val;

  assign rnd_up = {rem, 1'b0} >= {1'b0, den};
  assign q_rnd  = {1'b0, quo} + (QW + 1)'(rnd_up);
  assign q_lim  = neg ? LimNeg : LimPos;
  assign q_sat  = ovf || (q_rnd > q_lim);
  assign q_mag  = q_sat ? q_lim : q_rnd;
  assign q_val  = neg ? (-q_mag) : q_mag;

  logic signed [RESULT_WIDTH-1:0] slope_w, icpt_w;

  always_ff @(posedge clk) begin
    if (cmd.store_slope) slope_w <= q_val[RESULT_WIDTH-1:0];
    if (cmd.store_icpt)  icpt_w  <= q_val[RESULT_WIDTH-1:0];
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      slope      <= (cmd.out_status == FIT_OK) ? slope_w : '0;
      intercept  <= (cmd.out_status == FIT_OK) ? icpt_w : '0;
      fit_status <= cmd.out_status;
    end
  end

  assign sts.count_full = (count == MaxCount);
  assign sts.count_lt3  = (count < CW'(MIN_POINTS));
  assign sts.step_last  = (step_cnt == '0);
  assign sts.acc_zero   = (acc == '0);

`ifndef SYNTHESIS
  a_den_not_negative: assert property (@(posedge clk) disable iff (rst)
    cmd.load_den |-> !acc[AW-1])
    else $error("negative denominator");
`endif

endmodule
